### design/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif
`endif

### design/giot_pkg.sv
// Package for the greedy IoU object tracker: types, codes and class mapping.
// No dependencies.
package giot_pkg;

  localparam int unsigned MaxTracks = 32;
  localparam int unsigned IdxW      = $clog2(MaxTracks);
  localparam int unsigned CntW      = $clog2(MaxTracks + 1);

  localparam logic [1:0] TypePerson   = 2'd0;
  localparam logic [1:0] TypeHorse    = 2'd1;
  localparam logic [1:0] TypeVehicle  = 2'd2;
  localparam logic [1:0] TypeUnmapped = 2'd3;

  localparam logic [1:0] KindDetect   = 2'd0;
  localparam logic [1:0] KindBestShot = 2'd1;
  localparam logic [1:0] KindDone     = 2'd2;

  localparam logic       CmdDetect    = 1'b0;
  localparam logic       CmdEndFrame  = 1'b1;

  localparam logic [1:0] CfgIouThr    = 2'd0;
  localparam logic [1:0] CfgExpiry    = 2'd1;
  localparam logic [1:0] CfgShotDelay = 2'd2;
  localparam logic [1:0] CfgMinBox    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DRD, S_DA, S_DB, S_DC, S_DD, S_DE, S_DDEC, S_DWR,
    S_ERD, S_EWR, S_BRD, S_BCHK, S_DONE
  } state_e;

  typedef struct packed {
    logic        shot_sent;
    logic [15:0] number;
    logic [31:0] last_seen;
    logic [31:0] first_seen;
    logic [63:0] box;
    logic [7:0]  cls;
  } entry_t;

  function automatic logic [1:0] map_type(input logic [7:0] cls);
    logic [1:0] t;
    case (cls)
      8'd0:                   t = TypePerson;
      8'd17:                  t = TypeHorse;
      8'd2, 8'd3, 8'd5, 8'd7: t = TypeVehicle;
      default:                t = TypeUnmapped;
    endcase
    return t;
  endfunction

endpackage

### design/greedy_iou_object_tracker.sv
// Detection: each stored track is read and scored in turn, then the result is loaded.
// End of frame: stored tracks are read to expire them, kept tracks are scanned for best
// shots, then done is sent; each result waits in place while the output register is held.
// One request at a time: the next is taken only after its last result is loaded.
// Reset (async, active low) empties the table, frame and id counters to 1; no clearing pass.
// Depends on giot_pkg and assert_macros.svh.
`include "assert_macros.svh"

module greedy_iou_object_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // class_id[7:0], box_x, box_y, box_w, box_h, confidence
  input  logic [87:0]  s_axis_tdata,
  // command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // track_id, object_type, has_track, report, table_full, out_x, out_y, out_w,
  // out_h, out_confidence, zero pad
  output logic [103:0] m_axis_tdata,
  // kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  giot_pkg::state_e state_q, state_d;

  logic [7:0]  thr_q;
  logic [15:0] expiry_q, delay_q, minbox_q;

  logic [giot_pkg::CntW-1:0] count_q, idx_q, k_q;
  logic [31:0] frame_q;
  logic [15:0] next_q;

  logic [7:0]  cls_q;
  logic [15:0] x_q, y_q, w_q, h_q, conf_q;
  logic [31:0] da_q;

  logic                      best_found_q;
  logic [giot_pkg::IdxW-1:0] best_q;
  logic [32:0]               bi_q, bu_q;

  logic        elig_q;
  logic [16:0] iw_q, ih_q;
  logic [15:0] tw_q, th_q;
  logic [32:0] inter_q, uni_q;
  logic [31:0] at_q;
  logic [40:0] thp_q;
  logic [49:0] pa_lo_q, pb_lo_q;
  logic [48:0] pa_hi_q, pb_hi_q;

  giot_pkg::entry_t          mem [giot_pkg::MaxTracks];
  giot_pkg::entry_t          rd_q, wd;
  logic                      re, we;
  logic [giot_pkg::IdxW-1:0] ra, wa;

  logic         out_free, out_load;
  logic [1:0]   o_kind, o_type;
  logic [15:0]  o_id, o_x, o_y, o_w, o_h, o_conf;
  logic         o_has, o_rep, o_full, o_last;

  logic [15:0] tx, ty, tw, th, x1, y1;
  logic [16:0] ex, ey, dx, dy, x2, y2;
  logic [65:0] pa, pb;
  logic        pass, better, keep, shot_ok;
  logic [1:0]  det_type;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_comb begin
    tx = rd_q.box[15:0];
    ty = rd_q.box[31:16];
    tw = rd_q.box[47:32];
    th = rd_q.box[63:48];
    x1 = (tx > x_q) ? tx : x_q;
    y1 = (ty > y_q) ? ty : y_q;
    ex = {1'b0, tx} + {1'b0, tw};
    ey = {1'b0, ty} + {1'b0, th};
    dx = {1'b0, x_q} + {1'b0, w_q};
    dy = {1'b0, y_q} + {1'b0, h_q};
    x2 = (ex < dx) ? ex : dx;
    y2 = (ey < dy) ? ey : dy;
    pa = 66'(pa_lo_q) + (66'(pa_hi_q) << 17);
    pb = 66'(pb_lo_q) + (66'(pb_hi_q) << 17);
    pass   = elig_q && ({inter_q, 8'd0} > thp_q);
    better = !best_found_q || (pa > pb);
    keep   = (frame_q - rd_q.last_seen) <= {16'd0, expiry_q};
    shot_ok = !rd_q.shot_sent && (rd_q.last_seen == frame_q)
              && ((frame_q - rd_q.first_seen) >= {16'd0, delay_q})
              && (giot_pkg::map_type(rd_q.cls) != giot_pkg::TypeUnmapped);
    det_type = giot_pkg::map_type(cls_q);
  end

  always_comb begin
    state_d  = state_q;
    re       = 1'b0;
    ra       = idx_q[giot_pkg::IdxW-1:0];
    we       = 1'b0;
    wa       = idx_q[giot_pkg::IdxW-1:0];
    wd       = rd_q;
    out_free = !m_axis_tvalid || m_axis_tready;
    out_load = 1'b0;
    o_kind   = giot_pkg::KindDetect;
    o_id     = '0;
    o_type   = '0;
    o_has    = 1'b0;
    o_rep    = 1'b0;
    o_full   = 1'b0;
    o_x      = '0;
    o_y      = '0;
    o_w      = '0;
    o_h      = '0;
    o_conf   = '0;
    o_last   = 1'b0;
    s_axis_tready = (state_q == giot_pkg::S_IDLE);
    case (state_q)
      giot_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == giot_pkg::CmdEndFrame) ? giot_pkg::S_ERD
                                                           : giot_pkg::S_DRD;
        end
      end
      giot_pkg::S_DRD: begin
        if (idx_q < count_q) begin
          re = 1'b1;
          state_d = giot_pkg::S_DA;
        end else begin
          state_d = giot_pkg::S_DDEC;
        end
      end
      giot_pkg::S_DA: state_d = giot_pkg::S_DB;
      giot_pkg::S_DB: state_d = giot_pkg::S_DC;
      giot_pkg::S_DC: state_d = giot_pkg::S_DD;
      giot_pkg::S_DD: state_d = giot_pkg::S_DE;
      giot_pkg::S_DE: state_d = giot_pkg::S_DRD;
      giot_pkg::S_DDEC: begin
        re = best_found_q;
        ra = best_q;
        state_d = giot_pkg::S_DWR;
      end
      giot_pkg::S_DWR: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind = giot_pkg::KindDetect;
          o_type = det_type;
          o_x = x_q;
          o_y = y_q;
          o_w = w_q;
          o_h = h_q;
          o_conf = conf_q;
          o_last = 1'b1;
          if (best_found_q) begin
            we = 1'b1;
            wa = best_q;
            wd.box = {h_q, w_q, y_q, x_q};
            wd.last_seen = frame_q;
            o_id = rd_q.number;
            o_has = 1'b1;
          end else if (det_type != giot_pkg::TypeUnmapped) begin
            if (count_q < giot_pkg::CntW'(giot_pkg::MaxTracks)) begin
              we = 1'b1;
              wa = count_q[giot_pkg::IdxW-1:0];
              wd.cls = cls_q;
              wd.box = {h_q, w_q, y_q, x_q};
              wd.first_seen = frame_q;
              wd.last_seen = frame_q;
              wd.number = next_q;
              wd.shot_sent = 1'b0;
              o_id = next_q;
              o_has = 1'b1;
            end else begin
              o_full = 1'b1;
            end
          end
          o_rep = o_has && (w_q > minbox_q) && (h_q > minbox_q);
          state_d = giot_pkg::S_IDLE;
        end
      end
      giot_pkg::S_ERD: begin
        if (idx_q < count_q) begin
          re = 1'b1;
          state_d = giot_pkg::S_EWR;
        end else begin
          state_d = giot_pkg::S_BRD;
        end
      end
      giot_pkg::S_EWR: begin
        we = keep;
        wa = k_q[giot_pkg::IdxW-1:0];
        state_d = giot_pkg::S_ERD;
      end
      giot_pkg::S_BRD: begin
        if (idx_q < count_q) begin
          re = 1'b1;
          state_d = giot_pkg::S_BCHK;
        end else begin
          state_d = giot_pkg::S_DONE;
        end
      end
      giot_pkg::S_BCHK: begin
        if (!shot_ok) begin
          state_d = giot_pkg::S_BRD;
        end else if (out_free) begin
          out_load = 1'b1;
          o_kind = giot_pkg::KindBestShot;
          o_id = rd_q.number;
          o_type = giot_pkg::map_type(rd_q.cls);
          o_has = 1'b1;
          o_x = tx;
          o_y = ty;
          o_w = tw;
          o_h = th;
          we = 1'b1;
          wd.shot_sent = 1'b1;
          state_d = giot_pkg::S_BRD;
        end
      end
      giot_pkg::S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind = giot_pkg::KindDone;
          o_last = 1'b1;
          state_d = giot_pkg::S_IDLE;
        end
      end
      default: state_d = giot_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= giot_pkg::S_IDLE;
      thr_q         <= 8'd77;
      expiry_q      <= 16'd30;
      delay_q       <= 16'd3;
      minbox_q      <= 16'd65;
      count_q       <= '0;
      idx_q         <= '0;
      k_q           <= '0;
      frame_q       <= 32'd1;
      next_q        <= 16'd1;
      best_found_q  <= 1'b0;
      best_q        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          giot_pkg::CfgIouThr:    thr_q    <= cfg_data_i[7:0];
          giot_pkg::CfgExpiry:    expiry_q <= cfg_data_i;
          giot_pkg::CfgShotDelay: delay_q  <= cfg_data_i;
          giot_pkg::CfgMinBox:    minbox_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        giot_pkg::S_IDLE: begin
          idx_q <= '0;
          k_q <= '0;
          best_found_q <= 1'b0;
        end
        giot_pkg::S_DE: begin
          if (pass && better) begin
            best_found_q <= 1'b1;
            best_q <= idx_q[giot_pkg::IdxW-1:0];
          end
          idx_q <= idx_q + giot_pkg::CntW'(1);
        end
        giot_pkg::S_DWR: begin
          if (out_free && !best_found_q && det_type != giot_pkg::TypeUnmapped
              && count_q < giot_pkg::CntW'(giot_pkg::MaxTracks)) begin
            count_q <= count_q + giot_pkg::CntW'(1);
            next_q <= (next_q == 16'hFFFF) ? 16'd1 : next_q + 16'd1;
          end
        end
        giot_pkg::S_ERD: begin
          if (idx_q >= count_q) begin
            count_q <= k_q;
            idx_q <= '0;
          end
        end
        giot_pkg::S_EWR: begin
          if (keep) begin
            k_q <= k_q + giot_pkg::CntW'(1);
          end
          idx_q <= idx_q + giot_pkg::CntW'(1);
        end
        giot_pkg::S_BCHK: begin
          if (!shot_ok || out_free) begin
            idx_q <= idx_q + giot_pkg::CntW'(1);
          end
        end
        giot_pkg::S_DONE: begin
          if (out_free) begin
            frame_q <= frame_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == giot_pkg::S_IDLE && s_axis_tvalid) begin
      cls_q  <= s_axis_tdata[7:0];
      x_q    <= s_axis_tdata[23:8];
      y_q    <= s_axis_tdata[39:24];
      w_q    <= s_axis_tdata[55:40];
      h_q    <= s_axis_tdata[71:56];
      conf_q <= s_axis_tdata[87:72];
    end
    if (state_q == giot_pkg::S_DA) begin
      elig_q <= (rd_q.last_seen != frame_q) && (rd_q.cls == cls_q);
      iw_q <= (x2 > {1'b0, x1}) ? x2 - {1'b0, x1} : 17'd0;
      ih_q <= (y2 > {1'b0, y1}) ? y2 - {1'b0, y1} : 17'd0;
      tw_q <= tw;
      th_q <= th;
    end
    if (state_q == giot_pkg::S_DB) begin
      inter_q <= {16'd0, iw_q} * {16'd0, ih_q};
      at_q <= {16'd0, tw_q} * {16'd0, th_q};
      da_q <= {16'd0, w_q} * {16'd0, h_q};
    end
    if (state_q == giot_pkg::S_DC) begin
      uni_q <= {1'b0, at_q} + {1'b0, da_q} - inter_q;
    end
    if (state_q == giot_pkg::S_DD) begin
      thp_q   <= {33'd0, thr_q} * {8'd0, uni_q};
      pa_lo_q <= {17'd0, inter_q} * {33'd0, bu_q[16:0]};
      pa_hi_q <= {16'd0, inter_q} * {33'd0, bu_q[32:17]};
      pb_lo_q <= {17'd0, bi_q} * {33'd0, uni_q[16:0]};
      pb_hi_q <= {16'd0, bi_q} * {33'd0, uni_q[32:17]};
    end
    if (state_q == giot_pkg::S_DE && pass && better) begin
      bi_q <= inter_q;
      bu_q <= uni_q;
    end
    if (out_load) begin
      m_axis_tuser <= o_kind;
      m_axis_tlast <= o_last;
      m_axis_tdata <= {3'd0, o_conf, o_h, o_w, o_y, o_x, o_full, o_rep, o_has,
                       o_type, o_id};
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni,
    count_q <= giot_pkg::CntW'(giot_pkg::MaxTracks))
  `ASSERT_ALWAYS(a_id_nonzero, clk_i, rst_ni, next_q != 16'd0)
  `ASSERT_IMPL(a_frame_step, clk_i, rst_ni, frame_q != $past(frame_q),
    $past(state_q) == giot_pkg::S_DONE)
  `ASSERT_IMPL(a_accept_idle, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    ##1 (state_q == giot_pkg::S_DRD || state_q == giot_pkg::S_ERD))

endmodule

### verif/tb_greedy_iou_object_tracker.sv
// Testbench for greedy_iou_object_tracker: directed and random frames of detections,
// checked result by result against a behavioural tracker model held in a scoreboard.
// Depends on giot_pkg and the tracker RTL.
`timescale 1ns / 100ps

module tb_greedy_iou_object_tracker;

  localparam int NTrk = 32;
  localparam int StallLimit = 4000;

  typedef struct {
    logic [1:0]   kind;
    logic [103:0] data;
    logic         last;
  } track_result_t;

  class tracker_scoreboard;
    logic [7:0]  t_cls[NTrk];
    logic [15:0] t_x[NTrk], t_y[NTrk], t_w[NTrk], t_h[NTrk];
    logic [31:0] t_first[NTrk], t_last[NTrk];
    logic [15:0] t_num[NTrk];
    bit          t_shot[NTrk];
    int unsigned n_tracks;
    logic [31:0] frame;
    logic [15:0] next_id;
    logic [7:0]  iou_thr;
    logic [15:0] expiry, shot_delay, min_box;
    track_result_t pending_results[$];
    int errors;

    function new();
      n_tracks = 0; frame = 32'd1; next_id = 16'd1;
      iou_thr = 8'd77; expiry = 16'd30; shot_delay = 16'd3; min_box = 16'd65;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        giot_pkg::CfgIouThr:    iou_thr = val[7:0];
        giot_pkg::CfgExpiry:    expiry = val;
        giot_pkg::CfgShotDelay: shot_delay = val;
        giot_pkg::CfgMinBox:    min_box = val;
        default: ;
      endcase
    endfunction

    function logic [1:0] obj_type_of(logic [7:0] cls);
      if (cls == 0) return giot_pkg::TypePerson;
      if (cls == 17) return giot_pkg::TypeHorse;
      if (cls == 2 || cls == 3 || cls == 5 || cls == 7) return giot_pkg::TypeVehicle;
      return giot_pkg::TypeUnmapped;
    endfunction

    function logic [103:0] pack_res(logic [15:0] id, logic [1:0] ty, logic has, logic rep,
                                    logic full, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] w, logic [15:0] h, logic [15:0] c);
      return {3'b000, c, h, w, y, x, full, rep, has, ty, id};
    endfunction

    function void push(logic [1:0] k, logic [103:0] d, logic l);
      track_result_t r;
      r.kind = k; r.data = d; r.last = l;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void note_request(logic cmd, logic [87:0] d);
      logic [7:0] cls;
      logic [15:0] x, y, w, h, c;
      logic [1:0] ty;
      int best, k;
      longint unsigned bi, bu, inter, uni, iw, ih;
      int unsigned x1, y1, x2, y2, ex, ey, dx, dy;
      logic [127:0] p1, p2;
      logic [15:0] id;
      logic has, full, rep;
      if (cmd == giot_pkg::CmdDetect) begin
        cls = d[7:0]; x = d[23:8]; y = d[39:24]; w = d[55:40]; h = d[71:56];
        c = d[87:72];
        ty = obj_type_of(cls);
        best = -1; bi = 0; bu = 0; id = '0; has = 1'b0; full = 1'b0;
        for (int i = 0; i < n_tracks; i++) begin
          if (t_last[i] == frame || t_cls[i] != cls) continue;
          x1 = 32'((t_x[i] > x) ? t_x[i] : x);
          y1 = 32'((t_y[i] > y) ? t_y[i] : y);
          ex = 32'(t_x[i]) + 32'(t_w[i]); ey = 32'(t_y[i]) + 32'(t_h[i]);
          dx = 32'(x) + 32'(w); dy = 32'(y) + 32'(h);
          x2 = (ex < dx) ? ex : dx;
          y2 = (ey < dy) ? ey : dy;
          iw = (x2 > x1) ? x2 - x1 : 0;
          ih = (y2 > y1) ? y2 - y1 : 0;
          inter = iw * ih;
          uni = longint'(t_w[i]) * t_h[i] + longint'(w) * h - inter;
          if (!(256 * inter > longint'(iou_thr) * uni)) continue;
          p1 = 128'(inter) * 128'(bu);
          p2 = 128'(bi) * 128'(uni);
          if (best < 0 || p1 > p2) begin
            best = i; bi = inter; bu = uni;
          end
        end
        if (best >= 0) begin
          t_x[best] = x; t_y[best] = y; t_w[best] = w; t_h[best] = h;
          t_last[best] = frame;
          id = t_num[best]; has = 1'b1;
        end else if (ty != giot_pkg::TypeUnmapped) begin
          if (n_tracks < NTrk) begin
            k = n_tracks;
            t_cls[k] = cls; t_x[k] = x; t_y[k] = y; t_w[k] = w; t_h[k] = h;
            t_first[k] = frame; t_last[k] = frame; t_num[k] = next_id; t_shot[k] = 0;
            n_tracks++;
            id = next_id; has = 1'b1;
            next_id = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
          end else begin
            full = 1'b1;
          end
        end
        rep = has && (w > min_box) && (h > min_box);
        push(giot_pkg::KindDetect, pack_res(id, ty, has, rep, full, x, y, w, h, c), 1'b1);
      end else begin
        k = 0;
        for (int i = 0; i < n_tracks; i++) begin
          if (32'(frame - t_last[i]) > 32'(expiry)) continue;
          t_cls[k] = t_cls[i]; t_x[k] = t_x[i]; t_y[k] = t_y[i];
          t_w[k] = t_w[i]; t_h[k] = t_h[i]; t_first[k] = t_first[i];
          t_last[k] = t_last[i]; t_num[k] = t_num[i]; t_shot[k] = t_shot[i];
          k++;
        end
        n_tracks = k;
        for (int i = 0; i < n_tracks; i++) begin
          if (t_shot[i] || t_last[i] != frame) continue;
          if (32'(frame - t_first[i]) < 32'(shot_delay)) continue;
          if (obj_type_of(t_cls[i]) == giot_pkg::TypeUnmapped) continue;
          push(giot_pkg::KindBestShot,
               pack_res(t_num[i], obj_type_of(t_cls[i]), 1'b1, 1'b0, 1'b0,
                        t_x[i], t_y[i], t_w[i], t_h[i], 16'd0), 1'b0);
          t_shot[i] = 1;
        end
        push(giot_pkg::KindDone, '0, 1'b1);
        frame = frame + 32'd1;
      end
    endfunction

    function bit field_ok(string nm, logic [31:0] e, logic [31:0] a);
      if (e === a) return 1;
      if (errors < 10) $display("mismatch %s: expected %0h got %0h", nm, e, a);
      return 0;
    endfunction

    function void check_result(logic [1:0] k, logic [103:0] d, logic l);
      track_result_t e;
      bit ok;
      if (pending_results.size() == 0) begin
        if (errors < 10) $display("unexpected result kind %0d data %h", k, d);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      ok = field_ok("kind", e.kind, k);
      ok &= field_ok("track_id", e.data[15:0], d[15:0]);
      ok &= field_ok("object_type", e.data[17:16], d[17:16]);
      ok &= field_ok("has_track", e.data[18], d[18]);
      ok &= field_ok("report", e.data[19], d[19]);
      ok &= field_ok("table_full", e.data[20], d[20]);
      ok &= field_ok("out_x", e.data[36:21], d[36:21]);
      ok &= field_ok("out_y", e.data[52:37], d[52:37]);
      ok &= field_ok("out_w", e.data[68:53], d[68:53]);
      ok &= field_ok("out_h", e.data[84:69], d[84:69]);
      ok &= field_ok("out_confidence", e.data[100:85], d[100:85]);
      ok &= field_ok("last", e.last, l);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [103:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  tracker_scoreboard sb = new();
  bit calm = 0;
  int quiet_cycles = 0;

  typedef struct {
    logic [7:0] cls;
    logic [15:0] x, y, w, h;
  } seen_box_t;
  seen_box_t recent_boxes[$];

  always #5 clk_i = ~clk_i;

  greedy_iou_object_tracker u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  function bit take_gap();
    return !calm && ($urandom_range(0, 99) < 23);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
    m_axis_tready <= rst_ni && !take_gap();
  end

  task automatic send_request(logic cmd, logic [87:0] d);
    while (take_gap()) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(cmd, d);
  endtask

  task automatic detect(logic [7:0] cls, logic [15:0] x, logic [15:0] y, logic [15:0] w,
                        logic [15:0] h, logic [15:0] c);
    seen_box_t b;
    b.cls = cls; b.x = x; b.y = y; b.w = w; b.h = h;
    recent_boxes.insert(recent_boxes.size(), b);
    if (recent_boxes.size() > 24) void'(recent_boxes.pop_front());
    send_request(giot_pkg::CmdDetect, {c, h, w, y, x, cls});
  endtask

  task automatic end_frame();
    send_request(giot_pkg::CmdEndFrame, 88'({$urandom, $urandom, $urandom}));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_detection(int fresh_pct);
    logic [7:0] cls;
    seen_box_t b;
    int r;
    r = $urandom_range(0, 99);
    if (recent_boxes.size() > 0 && r >= fresh_pct) begin
      b = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
      detect(b.cls, b.x + 16'($urandom_range(0, 400)), b.y + 16'($urandom_range(0, 400)),
             b.w + 16'($urandom_range(0, 300)), b.h - 16'($urandom_range(0, 300)),
             16'($urandom));
    end else if (r < 12) begin
      detect(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0: cls = 8'd0;
        1: cls = 8'd17;
        2: cls = 8'd2;
        3: cls = 8'd3;
        4: cls = 8'd5;
        default: cls = 8'd7;
      endcase
      detect(cls, 16'($urandom_range(0, 50000)), 16'($urandom_range(0, 50000)),
             16'($urandom_range(40, 20000)), 16'($urandom_range(40, 20000)), 16'($urandom));
    end
  endtask

  task automatic random_frames(int n_items, int fresh_pct);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      for (int i = $urandom_range(0, 6); i > 0 && sent < n_items; i--) begin
        random_detection(fresh_pct);
        sent++;
      end
      end_frame();
      sent++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset settings
    detect(8'd0, 16'd1000, 16'd1000, 16'd5000, 16'd5000, 16'd1234);
    detect(8'd0, 16'd1000, 16'd1000, 16'd5000, 16'd5000, 16'd0);
    detect(8'd255, 16'd1000, 16'd1000, 16'd5000, 16'd5000, 16'hFFFF);
    detect(8'd17, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    detect(8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
    detect(8'd3, 16'd300, 16'd300, 16'd65, 16'd66, 16'd1);
    detect(8'd5, 16'd300, 16'd300, 16'd66, 16'd66, 16'd2);
    detect(8'd7, 16'hF000, 16'hF000, 16'h2000, 16'h2000, 16'd3);
    end_frame();
    detect(8'd0, 16'd1100, 16'd1000, 16'd5000, 16'd5000, 16'd10);
    detect(8'd0, 16'd1100, 16'd1000, 16'd5000, 16'd5000, 16'd11);
    detect(8'd17, 16'd0, 16'd0, 16'd0, 16'd0, 16'd12);
    detect(8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd13);
    end_frame();
    end_frame();
    detect(8'd0, 16'd1150, 16'd1000, 16'd5000, 16'd5000, 16'd20);
    end_frame();
    detect(8'd0, 16'd1150, 16'd1000, 16'd5000, 16'd5000, 16'd21);
    detect(8'd3, 16'd300, 16'd300, 16'd65, 16'd66, 16'd22);
    end_frame();

    // extremes low, no idling on the sender or receiver
    drain();
    calm = 1;
    write_reg(giot_pkg::CfgIouThr, 16'd0);
    write_reg(giot_pkg::CfgExpiry, 16'd0);
    write_reg(giot_pkg::CfgShotDelay, 16'd0);
    write_reg(giot_pkg::CfgMinBox, 16'd0);
    random_frames(40, 30);
    calm = 0;

    // extremes high: tracks pile up until the table overflows
    drain();
    write_reg(giot_pkg::CfgIouThr, 16'd255);
    write_reg(giot_pkg::CfgExpiry, 16'hFFFF);
    write_reg(giot_pkg::CfgShotDelay, 16'hFFFF);
    write_reg(giot_pkg::CfgMinBox, 16'hFFFF);
    for (int i = 0; i < 38; i++) random_detection(100);
    end_frame();
    drain();
    random_frames(12, 60);

    drain();
    write_reg(giot_pkg::CfgIouThr, 16'd128);
    write_reg(giot_pkg::CfgExpiry, 16'd2);
    write_reg(giot_pkg::CfgShotDelay, 16'd1);
    write_reg(giot_pkg::CfgMinBox, 16'd1000);
    random_frames(30, 25);
    drain();
    random_frames(30, 25);

    drain();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
